// ----- rtl/worm_pkg.sv -----
// Shared constants, types and helpers for the windowed outlier-rejecting mean.
// No dependencies; worm_if, worm_mul, the top module and the testbench import this package.
`default_nettype none
package worm_pkg;

  localparam int DATA_W           = 32;   // sample and result width
  localparam int LEN_W            = 7;    // window length and count fields
  localparam int WINDOW_DEPTH_DEF = 64;   // default ring depth
  localparam int MUL_W            = 64;   // multiplier operand width
  localparam int HALF_W           = MUL_W / 2;
  localparam int PROD_W           = 2 * MUL_W;
  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(16);

  // request into the shared multiplier
  typedef struct packed {
    logic              start;
    logic [MUL_W-1:0]  a;
    logic [MUL_W-1:0]  b;
  } mul_req_t;

endpackage
`default_nettype wire

// ----- rtl/worm_if.sv -----
// Valid/ready channel interfaces for the sample, result and config ports.
// Depends on worm_pkg for the payload widths.
`default_nettype none
interface worm_in_if;
  import worm_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] raw_offset;
  modport source (output valid, output raw_offset, input ready);
  modport sink   (input valid, input raw_offset, output ready);
endinterface

interface worm_out_if;
  import worm_pkg::*;
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] mean_offset;
  logic [LEN_W-1:0]  samples_held;
  logic [LEN_W-1:0]  outliers_dropped;
  modport source (output valid, output mean_offset, output samples_held,
                  output outliers_dropped, input ready);
  modport sink   (input valid, input mean_offset, input samples_held,
                  input outliers_dropped, output ready);
endinterface

interface worm_cfg_if;
  import worm_pkg::*;
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] window_length;
  modport source (output valid, output window_length, input ready);
  modport sink   (input valid, input window_length, output ready);
endinterface
`default_nettype wire

// ----- rtl/worm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module worm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- rtl/worm_mul.sv -----
// Shared 64x64 unsigned multiplier, one 32x32 partial product per cycle.
// Partial products other than low x low are skipped when an operand half is zero. Depends on worm_pkg.
`default_nettype none
module worm_mul (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire worm_pkg::mul_req_t       req,
  output logic                          done,
  output logic [worm_pkg::PROD_W-1:0]   prod
);
  import worm_pkg::*;

  logic [MUL_W-1:0]  a_r, b_r;
  logic [3:0]        rem_r, rem_nxt, pick;
  logic              busy_r, done_r;
  logic [PROD_W-1:0] acc_r, pp_sh;
  logic [HALF_W-1:0] ah, bh;
  logic [MUL_W-1:0]  pp;

  // pick the lowest pending partial product
  always_comb begin
    if (rem_r[0])      pick = 4'b0001;
    else if (rem_r[1]) pick = 4'b0010;
    else if (rem_r[2]) pick = 4'b0100;
    else               pick = 4'b1000;
    ah = (pick[2] | pick[3]) ? a_r[MUL_W-1:HALF_W] : a_r[HALF_W-1:0];
    bh = (pick[1] | pick[3]) ? b_r[MUL_W-1:HALF_W] : b_r[HALF_W-1:0];
    pp = MUL_W'(ah) * MUL_W'(bh);
    if (pick[0])      pp_sh = PROD_W'(pp);
    else if (pick[3]) pp_sh = {pp, {MUL_W{1'b0}}};
    else              pp_sh = PROD_W'({pp, {HALF_W{1'b0}}});
    rem_nxt = rem_r & ~pick;
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rem_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        rem_r  <= {(|req.a[MUL_W-1:HALF_W]) & (|req.b[MUL_W-1:HALF_W]),
                   (|req.a[MUL_W-1:HALF_W]) & (|req.b[HALF_W-1:0]),
                   (|req.a[HALF_W-1:0]) & (|req.b[MUL_W-1:HALF_W]),
                   1'b1};
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        if (rem_nxt == 4'b0000) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // operands and accumulator
  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r   <= req.a;
      b_r   <= req.b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + pp_sh;
    end
  end

  assign done = done_r;
  assign prod = acc_r;

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n) done_r |-> !busy_r)
    else $error("multiplier done while busy");
  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) req.start |-> !busy_r)
    else $error("multiplier started while busy");
  a_busy_work: assert property (@(posedge clk) disable iff (!rst_n) busy_r |-> rem_r != 4'b0000)
    else $error("multiplier busy with nothing pending");
endmodule
`default_nettype wire

// ----- rtl/windowed_outlier_rejecting_mean.sv -----
// Sliding-window mean that leaves out samples beyond two standard deviations.
// Per transaction: two passes over the held samples through one shared multiplier, a square
//   of the sum, then a 1-bit-per-cycle restoring divider of 32+clog2(DEPTH+1) steps (39).
// No new sample is taken until the result is loaded; input is not ready meanwhile.
// Reset (rst_n low, synchronous): window empty, write slot 0, window_length 16.
// Ring contents are not cleared; only written entries are ever read.
`default_nettype none
module windowed_outlier_rejecting_mean #(
  parameter int WINDOW_DEPTH = worm_pkg::WINDOW_DEPTH_DEF
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  worm_in_if.sink     in_ch,
  worm_out_if.source  out_ch,
  worm_cfg_if.sink    cfg_ch
);
  import worm_pkg::*;

  localparam int AW  = $clog2(WINDOW_DEPTH);
  localparam int CW  = $clog2(WINDOW_DEPTH + 1);
  localparam int SW  = DATA_W + CW;           // signed sum width
  localparam int DVW = $clog2(SW + 1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_P1_RD  = 4'd1;
  localparam logic [3:0] S_P1_SQ  = 4'd2;
  localparam logic [3:0] S_P1_SQW = 4'd3;
  localparam logic [3:0] S_P1_NW  = 4'd4;
  localparam logic [3:0] S_S1SQ   = 4'd5;
  localparam logic [3:0] S_S1SQW  = 4'd6;
  localparam logic [3:0] S_P2_RD  = 4'd7;
  localparam logic [3:0] S_P2_NO  = 4'd8;
  localparam logic [3:0] S_P2_NOW = 4'd9;
  localparam logic [3:0] S_P2_DW  = 4'd10;
  localparam logic [3:0] S_DIV    = 4'd11;
  localparam logic [3:0] S_DONE   = 4'd12;

  logic [3:0]        state_r, state_nxt;
  logic [LEN_W-1:0]  len_r;
  logic [AW-1:0]     wp_r, head_r, rd_ptr_r, rd_ptr_back;
  logic [CW-1:0]     fill_r, n_r, k_r, outl_r, len_eff, n_new;
  logic [CW:0]       fill_inc;
  logic [SW-1:0]     s1_r, kept_r, s1_mag, kept_fin, kept_mag;
  logic [PROD_W-1:0] ns2_r, rhs_r;
  logic [DATA_W-1:0] o_r, rdata, o_cur, o_mag;
  logic [SW-1:0]     no_mag, no_s;
  logic [SW:0]       diff, d_mag;
  logic [CW-1:0]     rem_r;
  logic [CW:0]       trial;
  logic [SW-1:0]     dq_r;
  logic [DVW-1:0]    dv_cnt_r;
  logic              kneg_r, last_k, mul_done;
  logic [PROD_W-1:0] mul_prod;
  mul_req_t          mul_req;
  logic              out_valid_r;
  logic [DATA_W-1:0] out_val_r, q_sign;
  logic [CW-1:0]     held_out_r, outl_out_r;

  worm_ram #(.WIDTH(DATA_W), .DEPTH(WINDOW_DEPTH)) u_ring (
    .clk   (clk),
    .we    (in_ch.valid && in_ch.ready),
    .waddr (wp_r),
    .wdata (in_ch.raw_offset),
    .raddr (rd_ptr_r),
    .rdata (rdata)
  );

  worm_mul u_mul (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (mul_req),
    .done (mul_done),
    .prod (mul_prod)
  );

  // effective window length and new fill count
  always_comb begin
    if (len_r == '0)                            len_eff = CW'(1);
    else if (32'(len_r) > 32'(WINDOW_DEPTH))    len_eff = CW'(WINDOW_DEPTH);
    else                                        len_eff = CW'(len_r);
    fill_inc = {1'b0, fill_r} + (CW+1)'(1);
    n_new    = (fill_inc > {1'b0, len_eff}) ? len_eff : fill_inc[CW-1:0];
  end

  // datapath helpers
  always_comb begin
    rd_ptr_back = (rd_ptr_r == '0) ? AW'(WINDOW_DEPTH - 1) : rd_ptr_r - AW'(1);
    last_k      = (k_r == n_r - CW'(1));
    o_cur       = (state_r == S_P1_SQ || state_r == S_P2_NO) ? rdata : o_r;
    o_mag       = o_cur[DATA_W-1] ? (~o_cur + DATA_W'(1)) : o_cur;
    s1_mag      = s1_r[SW-1] ? (~s1_r + SW'(1)) : s1_r;
    no_mag      = mul_prod[SW-1:0];
    no_s        = o_r[DATA_W-1] ? (~no_mag + SW'(1)) : no_mag;
    diff        = {no_s[SW-1], no_s} - {s1_r[SW-1], s1_r};
    d_mag       = diff[SW] ? (~diff + (SW+1)'(1)) : diff;
    kept_fin    = (mul_prod > rhs_r) ? (kept_r - SW'(signed'(o_r))) : kept_r;
    kept_mag    = kept_fin[SW-1] ? (~kept_fin + SW'(1)) : kept_fin;
    trial       = {rem_r, dq_r[SW-1]};
    q_sign      = kneg_r ? (~dq_r[DATA_W-1:0] + DATA_W'(1)) : dq_r[DATA_W-1:0];
  end

  // multiplier requests
  always_comb begin
    mul_req = '0;
    unique case (state_r)
      S_P1_SQ: begin
        mul_req = '{start: 1'b1, a: MUL_W'(o_mag), b: MUL_W'(o_mag)};
      end
      S_P1_SQW: begin
        mul_req = '{start: mul_done, a: mul_prod[MUL_W-1:0], b: MUL_W'(n_r)};
      end
      S_S1SQ: begin
        mul_req = '{start: 1'b1, a: MUL_W'(s1_mag), b: MUL_W'(s1_mag)};
      end
      S_P2_NO: begin
        mul_req = '{start: 1'b1, a: MUL_W'(n_r), b: MUL_W'(o_mag)};
      end
      S_P2_NOW: begin
        mul_req = '{start: mul_done, a: MUL_W'(d_mag), b: MUL_W'(d_mag)};
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_ch.valid) state_nxt = S_P1_RD;
      S_P1_RD:  state_nxt = S_P1_SQ;
      S_P1_SQ:  state_nxt = S_P1_SQW;
      S_P1_SQW: if (mul_done) state_nxt = S_P1_NW;
      S_P1_NW:  if (mul_done) state_nxt = last_k ? S_S1SQ : S_P1_RD;
      S_S1SQ:   state_nxt = S_S1SQW;
      S_S1SQW:  if (mul_done) state_nxt = S_P2_RD;
      S_P2_RD:  state_nxt = S_P2_NO;
      S_P2_NO:  state_nxt = S_P2_NOW;
      S_P2_NOW: if (mul_done) state_nxt = S_P2_DW;
      S_P2_DW:  if (mul_done) state_nxt = last_k ? S_DIV : S_P2_RD;
      S_DIV:    if (dv_cnt_r == DVW'(SW - 1)) state_nxt = S_DONE;
      S_DONE:   if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LEN_RESET;
      wp_r        <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid) begin
        len_r <= cfg_ch.window_length;
      end
      if (state_r == S_IDLE && in_ch.valid) begin
        wp_r   <= (wp_r == AW'(WINDOW_DEPTH - 1)) ? '0 : wp_r + AW'(1);
        fill_r <= n_new;
      end
      if (state_r == S_DONE && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        n_r      <= n_new;
        head_r   <= wp_r;
        rd_ptr_r <= wp_r;
        k_r      <= '0;
        s1_r     <= '0;
        ns2_r    <= '0;
      end
      S_P1_SQ: begin
        o_r  <= rdata;
        s1_r <= s1_r + SW'(signed'(rdata));
      end
      S_P1_NW: begin
        if (mul_done) begin
          ns2_r    <= ns2_r + mul_prod;
          k_r      <= k_r + CW'(1);
          rd_ptr_r <= rd_ptr_back;
        end
      end
      S_S1SQW: begin
        if (mul_done) begin
          rhs_r    <= (ns2_r - mul_prod) << 2;
          rd_ptr_r <= head_r;
          k_r      <= '0;
          kept_r   <= s1_r;
          outl_r   <= '0;
        end
      end
      S_P2_NO: begin
        o_r <= rdata;
      end
      S_P2_DW: begin
        if (mul_done) begin
          if (mul_prod > rhs_r) begin
            outl_r <= outl_r + CW'(1);
          end
          kept_r   <= kept_fin;
          k_r      <= k_r + CW'(1);
          rd_ptr_r <= rd_ptr_back;
          dv_cnt_r <= '0;
          rem_r    <= '0;
          // divider operands load as the last outlier test completes
          if (last_k) begin
            dq_r   <= kept_mag;
            kneg_r <= kept_fin[SW-1];
          end
        end
      end
      S_DIV: begin
        // restoring divide, one quotient bit per cycle
        dv_cnt_r <= dv_cnt_r + DVW'(1);
        if (trial >= {1'b0, n_r}) begin
          rem_r <= CW'(trial - {1'b0, n_r});
          dq_r  <= {dq_r[SW-2:0], 1'b1};
        end else begin
          rem_r <= trial[CW-1:0];
          dq_r  <= {dq_r[SW-2:0], 1'b0};
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_val_r  <= q_sign;
          held_out_r <= n_r;
          outl_out_r <= outl_r;
        end
      end
      default: begin
      end
    endcase
  end

  // ports
  assign in_ch.ready             = (state_r == S_IDLE);
  assign cfg_ch.ready            = 1'b1;
  assign out_ch.valid            = out_valid_r;
  assign out_ch.mean_offset      = out_val_r;
  assign out_ch.samples_held     = LEN_W'(held_out_r);
  assign out_ch.outliers_dropped = LEN_W'(outl_out_r);

  a_outl_le_n: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (outl_out_r <= held_out_r))
    else $error("more outliers than samples held");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= 32'(WINDOW_DEPTH))
    else $error("fill count above ring depth");
  a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (fill_r != '0))
    else $error("window empty after a sample");
  a_wp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wp_r) <= 32'(WINDOW_DEPTH - 1))
    else $error("write slot out of range");
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
// Testbench for windowed_outlier_rejecting_mean: drives offset samples and
// window-length writes, predicts each filtered result. Depends on worm_pkg, worm_if.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
  import worm_pkg::*;

  localparam int DEPTH     = WINDOW_DEPTH_DEF;
  localparam int EXP_SLOTS = 16;

  // Tracks the sample window and holds the expected filtered results
  class offset_scoreboard;
    logic signed [31:0] win_buf[DEPTH+1];   // oldest first
    int win_cnt;
    logic [6:0] win_len;
    logic signed [31:0] exp_mean[EXP_SLOTS];
    logic [6:0] exp_held[EXP_SLOTS];
    logic [6:0] exp_drop[EXP_SLOTS];
    int exp_wr;
    int exp_rd;
    int mismatches;
    int checked;

    function new();
      win_len = LEN_RESET;
      win_cnt = 0;
      exp_wr = 0;
      exp_rd = 0;
      mismatches = 0;
      checked = 0;
    endfunction

    function void set_length(logic [6:0] v);
      win_len = v;
    endfunction

    // note an accepted sample transaction and compute its expected result
    function void note_sample(logic signed [31:0] s);
      int len;
      int n;
      int drops;
      logic signed [127:0] s1;
      logic signed [127:0] s2;
      logic signed [127:0] rhs;
      logic signed [127:0] d;
      logic signed [127:0] kept;
      logic signed [127:0] res;
      len = win_len;
      if (len == 0) len = 1;
      if (len > DEPTH) len = DEPTH;
      win_buf[win_cnt] = s;
      win_cnt++;
      while (win_cnt > len) begin
        for (int j = 0; j < DEPTH; j++) win_buf[j] = win_buf[j+1];
        win_cnt--;
      end
      n = win_cnt;
      s1 = 0;
      s2 = 0;
      for (int i = 0; i < n; i++) begin
        s1 += win_buf[i];
        s2 += 128'(win_buf[i]) * win_buf[i];
      end
      rhs = 4 * (n * s2 - s1 * s1);
      kept = s1;
      drops = 0;
      for (int i = 0; i < n; i++) begin
        d = n * 128'(win_buf[i]) - s1;
        if (d * d > rhs) begin
          kept -= win_buf[i];
          drops++;
        end
      end
      res = kept / n;
      if (res > 128'sd2147483647) res = 128'sd2147483647;
      if (res < -128'sd2147483648) res = -128'sd2147483648;
      exp_mean[exp_wr % EXP_SLOTS] = res[31:0];
      exp_held[exp_wr % EXP_SLOTS] = 7'(n);
      exp_drop[exp_wr % EXP_SLOTS] = 7'(drops);
      exp_wr++;
    endfunction

    // compare one result transaction with the oldest expectation
    function void check_result(logic [31:0] mean, logic [6:0] held, logic [6:0] drop);
      logic [31:0] em;
      logic [6:0] eh;
      logic [6:0] ed;
      if (exp_wr == exp_rd) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result %0d", $signed(mean));
        return;
      end
      em = exp_mean[exp_rd % EXP_SLOTS];
      eh = exp_held[exp_rd % EXP_SLOTS];
      ed = exp_drop[exp_rd % EXP_SLOTS];
      exp_rd++;
      checked++;
      if (em !== mean || eh !== held || ed !== drop) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: result %0d: exp mean %0d held %0d drop %0d, got %0d %0d %0d",
                   checked, $signed(em), eh, ed, $signed(mean), held, drop);
      end
    endfunction

    function int pending();
      return exp_wr - exp_rd;
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   n_sent = 0;

  worm_in_if  in_ch();
  worm_out_if out_ch();
  worm_cfg_if cfg_ch();

  windowed_outlier_rejecting_mean i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  offset_scoreboard offset_sb = new();

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // result side: receiver stall pattern and checking
  int stall_mode = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready)
        offset_sb.check_result(out_ch.mean_offset, out_ch.samples_held,
                               out_ch.outliers_dropped);
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= ($urandom_range(0, 9) == 0);
      endcase
    end
  end

  // note every accepted sample transaction
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready) offset_sb.note_sample(in_ch.raw_offset);
  end

  int burst_left = 0;

  // send one sample, with bursty gaps in front; valid stays up inside a burst
  task automatic send_sample(input logic [31:0] v);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 30);
      if (gap > 0) in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.raw_offset <= v;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_sent++;
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (offset_sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_length(input logic [6:0] v);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.window_length <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    offset_sb.set_length(v);
  endtask

  // random sample: mostly clustered with spikes, sometimes full range
  function automatic logic [31:0] rand_sample(int base);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'(base + $signed($urandom_range(0, 2000000)) - 1000000);
      2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return 32'(base + $signed($urandom_range(0, 200)) - 100);
    endcase
  endfunction

  initial begin
    logic [6:0] lens[8];
    int base;
    in_ch.valid = 1'b0;
    in_ch.raw_offset = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.window_length = '0;
    lens = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd5, 7'd64, 7'd3, 7'd33};
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, identical values, one spike, default length 16
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h8000_0000);
    send_sample(32'h7FFF_FFFF);
    repeat (4) send_sample(32'd1000);
    send_sample(32'hFFFF_FC18);
    repeat (10) send_sample(32'd7);
    send_sample(32'd5000000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'h0);
    // shrink while full, then raise again
    write_length(7'd2);
    send_sample(32'd11);
    send_sample(32'd12);
    write_length(7'd64);
    send_sample(32'd13);
    send_sample(32'h8000_0000);

    // random phases through several window lengths, extremes included
    for (int p = 0; p < 8; p++) begin
      write_length(p == 7 ? 7'($urandom_range(0, 127)) : lens[p]);
      base = $signed($urandom()) >>> $urandom_range(0, 31);
      repeat (115) send_sample(rand_sample(base));
    end

    wait_idle();
    repeat (200) @(posedge clk);
    $display("Drove %0d offset samples through eleven window-length settings,", n_sent);
    $display("zero, one, two, full depth and oversize among them; %0d results checked.",
             offset_sb.checked);
    if (offset_sb.mismatches == 0 && offset_sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // timeout: about 1000 items, each with its latency, stalls and gaps
  initial begin
    #100_000_000;
    $display("Some tests failed");
    $finish;
  end
endmodule
`default_nettype wire

// ----- windowed_outlier_rejecting_mean.f -----
rtl/worm_pkg.sv
rtl/worm_if.sv
rtl/worm_ram.sv
rtl/worm_mul.sv
rtl/windowed_outlier_rejecting_mean.sv
tb/tb_top.sv
